FILE: rtl/tscs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the best-cut scan block.
// Depends on nothing; tscs_if, tscs_store and the scan module import it, tscs_div does not.
package tscs_pkg;

	localparam int MAX_ITEMS_DEF   = 1024;
	localparam int MAX_CLASSES_DEF = 16;

	localparam int X_W        = 32;
	localparam int LAB_W      = 4;
	localparam int WGT_W      = 16;
	localparam int SCORE_W    = 48;
	localparam int CC_CFG_W   = 5;
	localparam int MS_W       = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;
	localparam int Q_SHIFT    = 8;

	localparam logic [WGT_W-1:0]    WGT_ONE         = 16'd256;
	localparam logic [SCORE_W-1:0]  SCORE_MAX       = 48'hFFFF_FFFF_FFFF;
	localparam logic [CC_CFG_W-1:0] CLASS_COUNT_RST = 5'd2;
	localparam logic [MS_W-1:0]     MIN_SIDE_RST    = 10'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLASS_COUNT = 2'd0,
		CFG_MIN_SIDE    = 2'd1,
		CFG_WEIGHTED    = 2'd2,
		CFG_FLOOR       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [X_W-1:0] x_value;
		logic [LAB_W-1:0]      class_label;
		logic [WGT_W-1:0]      sample_weight;
	} item_t;

endpackage

FILE: rtl/tscs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input items, result items, configuration writes.
// Depends on tscs_pkg for field widths.
interface tscs_in_if;
	import tscs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] x_value;
	logic [LAB_W-1:0]      class_label;
	logic [WGT_W-1:0]      sample_weight;
	logic                  last_item;
	modport source(output valid, x_value, class_label, sample_weight, last_item, input ready);
	modport sink(input valid, x_value, class_label, sample_weight, last_item, output ready);
endinterface

interface tscs_out_if;
	import tscs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] best_cut;
	logic [SCORE_W-1:0]    best_score;
	logic                  split_found;
	modport source(output valid, best_cut, best_score, split_found, input ready);
	modport sink(input valid, best_cut, best_score, split_found, output ready);
endinterface

interface tscs_cfg_if;
	import tscs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/tscs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module tscs_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] nq_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, nq_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			nq_q  <= {nq_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule

FILE: rtl/tscs_store.sv
`timescale 1ns / 1ps
// Observation memory: one write port, one registered read port.
// Depends on tscs_pkg for the item record.
module tscs_store #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  tscs_pkg::item_t wr_data,
	input  logic [AW-1:0]   rd_addr,
	output tscs_pkg::item_t rd_data
);
	import tscs_pkg::*;

	item_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/tree_split_best_cut_scan.sv
`timescale 1ns / 1ps
// Best-cut scan: loading takes one item per cycle; ready stays high until the last item.
// After the last item the range check runs in states PRE0, PRE1 and PRE2; then every item up to one past
// the last cut position passes FETCH, ARRIVE and ADDS, and each scored cut adds the squaring of both sides
// per class in the shared squarer and two divisions in the one-bit-per-cycle divider (NUM_W = 64 by default).
// The final state hands the result item to the output register once it is free; there it waits.
// Reset restores the register defaults and clears class totals; the item store is not cleared.
module tree_split_best_cut_scan #(
	parameter int MAX_ITEMS   = tscs_pkg::MAX_ITEMS_DEF,
	parameter int MAX_CLASSES = tscs_pkg::MAX_CLASSES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tscs_in_if.sink   in_ch,
	tscs_out_if.source out_ch,
	tscs_cfg_if.sink  cfg_ch
);
	import tscs_pkg::*;

	localparam int AW     = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int WSUM_W = WGT_W + $clog2(MAX_ITEMS);
	localparam int CIDX_W = $clog2(MAX_CLASSES);
	localparam int CC_W   = $clog2(MAX_CLASSES + 1);
	localparam int SQ_W   = 2 * WSUM_W + CIDX_W;
	localparam int NUM_W  = SQ_W + Q_SHIFT;
	localparam int XW     = CNT_W + MS_W + 1;
	localparam int SUM_W  = (NUM_W + 1 > SCORE_W) ? NUM_W + 1 : SCORE_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PRE0, ST_PRE1, ST_PRE2, ST_FETCH, ST_ARRIVE, ST_MUL, ST_ACC,
		ST_DVL_GO, ST_DVL_WT, ST_DVR_GO, ST_DVR_WT, ST_CMP, ST_ADDS, ST_FIN
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CC_CFG_W-1:0] class_count_q;
	logic [MS_W-1:0]     min_side_q;
	logic                weighted_q;
	logic [SCORE_W-1:0]  floor_q;

	// Batch state.
	logic [CNT_W-1:0]  n_q;
	logic [WSUM_W-1:0] wt_q;
	logic [WSUM_W-1:0] tot_q  [MAX_CLASSES];
	logic [WSUM_W-1:0] left_q [MAX_CLASSES];

	// Sweep state.
	logic signed [X_W-1:0] v0_q, prev_v_q, cur_v_q, cand_q, cut_q;
	logic [CNT_W-1:0]      lo_q, hi_q, j_q;
	logic [CC_W-1:0]       ncls_q, c_q;
	logic                  ph_q;
	logic [LAB_W-1:0]      cur_lab_q;
	logic [WGT_W-1:0]      cur_w_q;
	logic [WSUM_W-1:0]     wl_q;
	logic [SQ_W-1:0]       sl_q, sr_q;
	logic [2*WSUM_W-1:0]   prod_q;
	logic [NUM_W-1:0]      ql_q;
	logic [SCORE_W-1:0]    score_q, best_q;
	logic                  found_q;

	// Result register.
	logic                  out_valid_q;
	logic signed [X_W-1:0] out_cut_q;
	logic [SCORE_W-1:0]    out_score_q;
	logic                  out_found_q;

	// Datapath nets.
	logic                  in_acc, store_ok, in_lab_ok, cur_lab_ok, wr_en, cut_ok, pre_ok;
	logic [WGT_W-1:0]      w_in;
	item_t                 wr_item, rd_item;
	logic [AW-1:0]         rd_addr;
	logic [CNT_W-1:0]      nm1;
	logic [CIDX_W-1:0]     aidx;
	logic [WSUM_W-1:0]     tot_rd, left_rd, right_rd, mul_op, wr_w;
	logic [2*WSUM_W-1:0]   mul_p;
	logic [MS_W-1:0]       nmin;
	logic [XW-1:0]         lo_x, hi_x;
	logic [CC_W-1:0]       ncls;
	logic [X_W:0]          pair_sum;
	logic                  div_start, div_done;
	logic [NUM_W-1:0]      div_num, div_quo;
	logic [WSUM_W-1:0]     div_den;
	logic [SUM_W-1:0]      score_sum;
	logic [SCORE_W-1:0]    score_sat;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign in_acc       = in_ch.valid && in_ch.ready;

	// Loading: an unweighted item counts as 1.0 in Q8.8. Items past the store size
	// are dropped, but their last-item mark still starts the sweep.
	assign w_in      = weighted_q ? in_ch.sample_weight : WGT_ONE;
	assign store_ok  = n_q < CNT_W'(MAX_ITEMS);
	assign in_lab_ok = 32'(in_ch.class_label) < 32'(MAX_CLASSES);
	assign cur_lab_ok = 32'(cur_lab_q) < 32'(MAX_CLASSES);
	assign wr_en     = in_acc && store_ok;
	assign wr_item   = '{x_value: in_ch.x_value, class_label: in_ch.class_label,
		sample_weight: w_in};

	assign nm1 = n_q - CNT_W'(1);

	always_comb begin
		case (state_q)
			ST_PRE0: rd_addr = '0;
			ST_PRE1: rd_addr = nm1[AW-1:0];
			default: rd_addr = j_q[AW-1:0];
		endcase
	end

	tscs_store #(.DEPTH(MAX_ITEMS)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (n_q[AW-1:0]),
		.wr_data (wr_item),
		.rd_addr (rd_addr),
		.rd_data (rd_item)
	);

	// The per-class arrays are read at one index at a time: the incoming label while
	// loading, the current item's label while adding it to the left side, and the
	// class counter while the score terms are squared.
	always_comb begin
		case (state_q)
			ST_IDLE: aidx = CIDX_W'(in_ch.class_label);
			ST_ADDS: aidx = CIDX_W'(cur_lab_q);
			default: aidx = c_q[CIDX_W-1:0];
		endcase
	end

	assign tot_rd   = tot_q[aidx];
	assign left_rd  = left_q[aidx];
	assign right_rd = tot_rd - left_rd;
	assign mul_op   = ph_q ? right_rd : left_rd;
	assign mul_p    = mul_op * mul_op;

	// Sweep bounds. A side minimum of zero acts as one.
	assign nmin   = (min_side_q == '0) ? MS_W'(1) : min_side_q;
	assign lo_x   = XW'(nmin) - XW'(1);
	assign hi_x   = XW'(n_q) - XW'(nmin) - XW'(1);
	assign pre_ok = (n_q >= CNT_W'(2)) && (XW'(n_q) >= XW'({nmin, 1'b0}))
		&& (v0_q != rd_item.x_value);
	assign ncls   = (32'(class_count_q) > 32'(MAX_CLASSES)) ? CC_W'(MAX_CLASSES)
		: CC_W'(class_count_q);

	// A cut between the previous item and the one just read counts only past the left
	// minimum, between distinct values, and with weight on both sides.
	assign wr_w     = wt_q - wl_q;
	assign cut_ok   = (j_q > lo_q) && (prev_v_q != rd_item.x_value)
		&& (wl_q != '0) && (wr_w != '0);
	assign pair_sum = {prev_v_q[X_W-1], prev_v_q} + {rd_item.x_value[X_W-1], rd_item.x_value};

	// Each side's term is floor(S * 256 / W), which gives Q48.16; the summed score saturates to Q32.16.
	assign div_start = (state_q == ST_DVL_GO) || (state_q == ST_DVR_GO);
	assign div_num   = (state_q == ST_DVL_GO) ? {sl_q, {Q_SHIFT{1'b0}}}
		: {sr_q, {Q_SHIFT{1'b0}}};
	assign div_den   = (state_q == ST_DVL_GO) ? wl_q : wr_w;

	tscs_div #(.NUM_W(NUM_W), .DEN_W(WSUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign score_sum = SUM_W'(ql_q) + SUM_W'(div_quo);
	assign score_sat = (score_sum > SUM_W'(SCORE_MAX)) ? SCORE_MAX : score_sum[SCORE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			class_count_q <= CLASS_COUNT_RST;
			min_side_q    <= MIN_SIDE_RST;
			weighted_q    <= 1'b0;
			floor_q       <= '0;
			n_q           <= '0;
			wt_q          <= '0;
			for (int k = 0; k < MAX_CLASSES; k++) begin
				tot_q[k]  <= '0;
				left_q[k] <= '0;
			end
			v0_q        <= '0;
			prev_v_q    <= '0;
			cur_v_q     <= '0;
			cand_q      <= '0;
			cut_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			j_q         <= '0;
			ncls_q      <= '0;
			c_q         <= '0;
			ph_q        <= 1'b0;
			cur_lab_q   <= '0;
			cur_w_q     <= '0;
			wl_q        <= '0;
			sl_q        <= '0;
			sr_q        <= '0;
			prod_q      <= '0;
			ql_q        <= '0;
			score_q     <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_cut_q   <= '0;
			out_score_q <= '0;
			out_found_q <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				case (cfg_idx_t'(cfg_ch.index))
					CFG_CLASS_COUNT: class_count_q <= cfg_ch.data[CC_CFG_W-1:0];
					CFG_MIN_SIDE:    min_side_q    <= cfg_ch.data[MS_W-1:0];
					CFG_WEIGHTED:    weighted_q    <= cfg_ch.data[0];
					CFG_FLOOR:       floor_q       <= cfg_ch.data[SCORE_W-1:0];
					default:         floor_q       <= floor_q;
				endcase
			end

			// In the final state the hand-over below decides the valid flag itself.
			if (out_valid_q && out_ch.ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (store_ok) begin
							n_q  <= n_q + CNT_W'(1);
							wt_q <= wt_q + WSUM_W'(w_in);
							if (in_lab_ok) begin
								tot_q[aidx] <= tot_rd + WSUM_W'(w_in);
							end
						end
						if (in_ch.last_item) begin
							best_q  <= floor_q;
							found_q <= 1'b0;
							cut_q   <= '0;
							state_q <= ST_PRE0;
						end
					end
				end
				ST_PRE0: state_q <= ST_PRE1;
				ST_PRE1: begin
					v0_q    <= rd_item.x_value;
					state_q <= ST_PRE2;
				end
				ST_PRE2: begin
					// The last stored value is on the read port; equal ends mean no split.
					lo_q   <= lo_x[CNT_W-1:0];
					hi_q   <= hi_x[CNT_W-1:0];
					ncls_q <= ncls;
					j_q    <= '0;
					wl_q   <= '0;
					state_q <= pre_ok ? ST_FETCH : ST_FIN;
				end
				ST_FETCH: state_q <= ST_ARRIVE;
				ST_ARRIVE: begin
					cur_v_q   <= rd_item.x_value;
					cur_lab_q <= rd_item.class_label;
					cur_w_q   <= rd_item.sample_weight;
					if (cut_ok) begin
						cand_q  <= pair_sum[X_W:1];
						c_q     <= '0;
						ph_q    <= 1'b0;
						sl_q    <= '0;
						sr_q    <= '0;
						state_q <= (ncls_q == '0) ? ST_DVL_GO : ST_MUL;
					end else begin
						state_q <= ST_ADDS;
					end
				end
				ST_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// Left square first, then right square, then the next class.
					if (!ph_q) begin
						sl_q    <= sl_q + SQ_W'(prod_q);
						ph_q    <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						sr_q <= sr_q + SQ_W'(prod_q);
						ph_q <= 1'b0;
						c_q  <= c_q + CC_W'(1);
						state_q <= (c_q == ncls_q - CC_W'(1)) ? ST_DVL_GO : ST_MUL;
					end
				end
				ST_DVL_GO: state_q <= ST_DVL_WT;
				ST_DVL_WT: begin
					if (div_done) begin
						ql_q    <= div_quo;
						state_q <= ST_DVR_GO;
					end
				end
				ST_DVR_GO: state_q <= ST_DVR_WT;
				ST_DVR_WT: begin
					if (div_done) begin
						score_q <= score_sat;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					// Strictly greater wins, so the first of equal cuts is kept.
					if (score_q > best_q) begin
						best_q  <= score_q;
						cut_q   <= cand_q;
						found_q <= 1'b1;
					end
					state_q <= ST_ADDS;
				end
				ST_ADDS: begin
					if (j_q <= hi_q) begin
						wl_q <= wl_q + WSUM_W'(cur_w_q);
						if (cur_lab_ok) begin
							left_q[aidx] <= left_rd + WSUM_W'(cur_w_q);
						end
						prev_v_q <= cur_v_q;
						j_q      <= j_q + CNT_W'(1);
						state_q  <= ST_FETCH;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Hand the result over once the output register is free, then
					// clear the batch for the next set of observations.
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_cut_q   <= cut_q;
						out_score_q <= best_q;
						out_found_q <= found_q;
						n_q         <= '0;
						wt_q        <= '0;
						for (int k = 0; k < MAX_CLASSES; k++) begin
							tot_q[k]  <= '0;
							left_q[k] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.best_cut    = out_cut_q;
	assign out_ch.best_score  = out_score_q;
	assign out_ch.split_found = out_found_q;

	// A result without a split carries a zero cut.
	a_no_split_zero_cut: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.split_found |-> out_ch.best_cut == '0)
		else $error("result without split carries a nonzero cut");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DVL_WT) || (state_q == ST_DVR_WT))
		else $error("divider finished outside a wait state");

	// Accepting the last item closes the input until the sweep is over.
	a_last_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_ch.last_item |=> !in_ch.ready)
		else $error("input still ready after the last item");

	// The left weight never exceeds the batch total during the sweep.
	a_left_within_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> wl_q <= wt_q)
		else $error("left weight exceeds total weight");

endmodule
